### sv/ita_pkg.sv
// shared constants, types and helpers for the integer to radix ascii block
// no dependencies; every other file of the block refers to this package
`timescale 1ns / 1ps

package ita_pkg;

   // default width of the converted integer
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // width of the configuration registers and of the csr data
   localparam int CFG_WIDTH = 6;
   localparam int CSR_INDEX_WIDTH = 2;

   // digit width: one digit of a radix up to thirty-six
   localparam int DIGIT_WIDTH = 6;

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUMBER_BASE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUFFER_LENGTH = 2'd1;

   // radix limits and reset values
   localparam logic [CFG_WIDTH-1:0] BASE_MIN     = 6'd2;
   localparam logic [CFG_WIDTH-1:0] BASE_MAX     = 6'd36;
   localparam logic [CFG_WIDTH-1:0] BASE_RESET   = 6'd10;
   localparam logic [CFG_WIDTH-1:0] LENGTH_RESET = 6'd10;

   // ascii codes
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   // divider status toward the controller
   typedef struct packed {
      logic done;
      logic quotient_zero;
   } div_status_type;

   // digit stack control
   typedef struct packed {
      logic push;
      logic pop;
   } lifo_ctrl_type;

   // digit value to its ascii character, 0-9 then a-z
   function automatic logic [7:0] ascii_digit(input logic [DIGIT_WIDTH-1:0] digit);
      logic [7:0] wide;
      wide = {2'b00, digit};
      if (digit < 6'd10) begin
         ascii_digit = CHAR_ZERO + wide;
      end else begin
         ascii_digit = CHAR_LOWER_A + wide - 8'd10;
      end
   endfunction

endpackage

### sv/ita_if.sv
// valid/ready channel interfaces: input value, text result and csr write
// depends on ita_pkg for widths
`timescale 1ns / 1ps

interface ita_req_if #(
   parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface ita_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;
   logic       overflow;

   modport source (output valid, output character, output last, output overflow,
                   input ready);
   modport sink   (input valid, input character, input last, input overflow,
                   output ready);
endinterface

interface ita_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ita_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [ita_pkg::CFG_WIDTH-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/ita_div.sv
// bit-serial restoring divider: one quotient bit per cycle by a 6-bit radix
// depends on ita_pkg for the status struct and digit width
`timescale 1ns / 1ps

module ita_div #(
   parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [VALUE_WIDTH-1:0]              dividend,
   input  logic [ita_pkg::DIGIT_WIDTH-1:0]     divisor,
   output logic [VALUE_WIDTH-1:0]              quotient,
   output logic [ita_pkg::DIGIT_WIDTH-1:0]     remainder,
   output ita_pkg::div_status_type             status
);

   localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int DW = ita_pkg::DIGIT_WIDTH;

   logic [VALUE_WIDTH-1:0]   quo_ff, quo_in;
   logic [DW-1:0]            rem_ff, rem_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DW:0]              partial;
   logic [DW:0]              diff;
   logic                     fits;

   // one shift-subtract step
   assign partial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff    = partial - {1'b0, divisor};
   assign fits    = partial >= {1'b0, divisor};

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         quo_in     = dividend;
         rem_in     = '0;
         bit_cnt_in = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in     = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in     = fits ? diff[DW-1:0] : partial[DW-1:0];
         bit_cnt_in = bit_cnt_ff + BIT_CNT_WIDTH'(1);
         if (bit_cnt_ff == BIT_CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
   end

   assign quotient             = quo_ff;
   assign remainder            = rem_ff;
   assign status.done          = done_ff;
   assign status.quotient_zero = (quo_ff == '0);

endmodule

### sv/ita_lifo.sv
// digit stack as a shift line: push in at the top, pop from the top
// depends on ita_pkg for the control struct and digit width
`timescale 1ns / 1ps

module ita_lifo #(
   parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  ita_pkg::lifo_ctrl_type          ctrl,
   input  logic [ita_pkg::DIGIT_WIDTH-1:0] push_digit,
   output logic [ita_pkg::DIGIT_WIDTH-1:0] top_digit
);

   localparam int DW = ita_pkg::DIGIT_WIDTH;

   logic [DW-1:0] stack_ff [VALUE_WIDTH];
   logic [DW-1:0] stack_in [VALUE_WIDTH];

   // shift down on push, up on pop
   always_comb begin
      for (int i = 0; i < VALUE_WIDTH; i++) begin
         stack_in[i] = stack_ff[i];
      end
      if (ctrl.push) begin
         stack_in[0] = push_digit;
         for (int i = 1; i < VALUE_WIDTH; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end else if (ctrl.pop) begin
         for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < VALUE_WIDTH; i++) begin
         stack_ff[i] <= stack_in[i];
      end
   end

   assign top_digit = stack_ff[0];

endmodule

### sv/integer_to_radix_ascii.sv
// top level: signed integer to ascii text in a configurable radix
// depends on ita_pkg, ita_if, ita_div and ita_lifo
`timescale 1ns / 1ps

// Usage
//   req_ch carries one signed integer per transfer. rsp_ch returns its text one
//   ascii character per transfer: '-' for a negative value, then the digits
//   from most significant down (0-9, a-z), last set on the final one. If the
//   text with sign does not fit buffer_length less one, or the radix is outside
//   2 to 36, a single transfer with character 0, last and overflow set is given.
//   csr_ch writes number_base (index 0) and buffer_length (index 1); it is
//   always ready and should only be written while no conversion is running.
// Sequence
//   Each digit takes one pass of the bit-serial divider over all VALUE_WIDTH
//   quotient bits, from the least significant digit up. One item is
//   converted at a time; req_ch is ready only while the converter is idle.
// Reset and stall
//   Synchronous reset sets the radix and buffer length to ten and drops any
//   item in progress. Characters leave through an output register; while the
//   receiver stalls the character is held and the converter waits.

module integer_to_radix_ascii #(
   parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ita_req_if.sink    req_ch,
   ita_rsp_if.source  rsp_ch,
   ita_csr_if.sink    csr_ch
);

   localparam int CW = ita_pkg::CFG_WIDTH;
   localparam int DW = ita_pkg::DIGIT_WIDTH;
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int CMP_WIDTH = ((CNT_WIDTH > CW) ? CNT_WIDTH : CW) + 1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DIV    = 6'b000010,
      S_CHECK  = 6'b000100,
      S_SIGN   = 6'b001000,
      S_DIGITS = 6'b010000,
      S_ERROR  = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           number_base_ff, number_base_in;
   logic [CW-1:0]           buffer_length_ff, buffer_length_in;
   logic                    neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]    ndig_ff, ndig_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic                    req_transfer;
   logic                    out_free;
   logic                    in_neg;
   logic [VALUE_WIDTH-1:0]  in_mag;
   logic                    base_ok;
   logic                    div_start;
   logic [VALUE_WIDTH-1:0]  div_dividend;
   logic [VALUE_WIDTH-1:0]  div_quotient;
   logic [DW-1:0]           div_remainder;
   ita_pkg::div_status_type div_status;
   ita_pkg::lifo_ctrl_type  lifo_ctrl;
   logic [DW-1:0]           top_digit;
   logic [CMP_WIDTH-1:0]    need;
   logic [CMP_WIDTH-1:0]    room;

   // handshakes
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_transfer = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // sign and magnitude; most negative value keeps its unsigned magnitude
   assign in_neg  = req_ch.value[VALUE_WIDTH-1];
   assign in_mag  = in_neg ? (~req_ch.value + VALUE_WIDTH'(1)) : req_ch.value;
   assign base_ok = (number_base_ff >= ita_pkg::BASE_MIN) &&
                    (number_base_ff <= ita_pkg::BASE_MAX);

   // length check operands
   assign need = CMP_WIDTH'(ndig_ff) + CMP_WIDTH'(neg_ff);
   assign room = (buffer_length_ff == '0) ? '0 :
                 (CMP_WIDTH'(buffer_length_ff) - CMP_WIDTH'(1));

   // divider feed: input magnitude first, then each quotient
   assign div_dividend = (state_ff == S_IDLE) ? in_mag : div_quotient;

   // csr writes
   always_comb begin
      number_base_in   = number_base_ff;
      buffer_length_in = buffer_length_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            ita_pkg::CSR_NUMBER_BASE:   number_base_in   = csr_ch.data;
            ita_pkg::CSR_BUFFER_LENGTH: buffer_length_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   // conversion sequencer
   always_comb begin
      state_in       = state_ff;
      neg_in         = neg_ff;
      ndig_in        = ndig_ff;
      div_start      = 1'b0;
      lifo_ctrl.push = 1'b0;
      lifo_ctrl.pop  = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_transfer) begin
               neg_in  = in_neg;
               ndig_in = '0;
               if (base_ok) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  state_in = S_ERROR;
               end
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               lifo_ctrl.push = 1'b1;
               ndig_in        = ndig_ff + CNT_WIDTH'(1);
               if (div_status.quotient_zero) begin
                  state_in = S_CHECK;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (need > room) begin
               state_in = S_ERROR;
            end else if (neg_ff) begin
               state_in = S_SIGN;
            end else begin
               state_in = S_DIGITS;
            end
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ita_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_ovf_in   = 1'b0;
               state_in     = S_DIGITS;
            end
         end
         S_DIGITS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = ita_pkg::ascii_digit(top_digit);
               rsp_last_in   = (ndig_ff == CNT_WIDTH'(1));
               rsp_ovf_in    = 1'b0;
               lifo_ctrl.pop = 1'b1;
               ndig_in       = ndig_ff - CNT_WIDTH'(1);
               if (ndig_ff == CNT_WIDTH'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ita_pkg::CHAR_NONE;
               rsp_last_in  = 1'b1;
               rsp_ovf_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         number_base_ff   <= ita_pkg::BASE_RESET;
         buffer_length_ff <= ita_pkg::LENGTH_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         number_base_ff   <= number_base_in;
         buffer_length_ff <= buffer_length_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      ndig_ff     <= ndig_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // result channel
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.character = rsp_char_ff;
   assign rsp_ch.last      = rsp_last_ff;
   assign rsp_ch.overflow  = rsp_ovf_ff;

   // bit-serial divider
   ita_div #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (number_base_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // digit stack, least significant digit pushed first
   ita_lifo #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_lifo (
      .clock      (clock),
      .ctrl       (lifo_ctrl),
      .push_digit (div_remainder),
      .top_digit  (top_digit)
   );

endmodule
